>>> rtl/core/assert_macros.svh
// Assertion helpers for the lattice engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BLME_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BLME_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BLME_ASSERT(label, clk, rstn, prop, msg)
`define BLME_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

>>> rtl/core/blme_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package blme_pkg;
    localparam int CoordBits  = 6;
    localparam int SegBits    = 12;
    localparam int SlotBits   = 2;
    localparam int KindBits   = 4;
    localparam int CellBits   = 14;
    localparam int PosBits    = 3 * CoordBits;
    localparam int LatBits    = 3 * CoordBits;
    localparam int PartBits   = SegBits + SlotBits;
    localparam int CountBits  = 3;
    localparam int SqBits     = 12;
    localparam int NbrCount   = 54;
    localparam int MaxBonds   = 4;

    localparam logic [2:0] OP_PLACE = 3'd0;
    localparam logic [2:0] OP_CLEAR = 3'd1;
    localparam logic [2:0] OP_CHECK = 3'd2;
    localparam logic [2:0] OP_ENERGY = 3'd3;
    localparam logic [2:0] OP_BCHECK = 3'd4;
    localparam logic [2:0] OP_SETBOND = 3'd5;

    localparam logic [CellBits-1:0] CELL_EMPTY  = 14'd0;
    localparam logic [CellBits-1:0] CELL_CORNER = 14'd1;
    localparam logic [CellBits-1:0] CELL_ORIGIN = 14'd2;

    typedef logic [8:0] t_off;
    typedef t_off t_off_tab [0:NbrCount-1];

    // Every offset in the 5x5x5 box whose squared length is 4, 5 or 6.
    function automatic t_off_tab build_nbr();
        t_off_tab tab;
        int n;
        int s;
        n = 0;
        for (int dx = -2; dx <= 2; dx++) begin
            for (int dy = -2; dy <= 2; dy++) begin
                for (int dz = -2; dz <= 2; dz++) begin
                    s = dx * dx + dy * dy + dz * dz;
                    if (s >= 4 && s <= 6 && n < NbrCount) begin
                        tab[n] = {3'(dx), 3'(dy), 3'(dz)};
                        n++;
                    end
                end
            end
        end
        return tab;
    endfunction

    localparam t_off_tab NBR_TAB = build_nbr();
endpackage
`default_nettype wire

>>> rtl/core/bfm_lattice_move_engine.sv
// One item is in work at a time; the lattice memory port (one access per cycle)
// and the 54-cell neighbor scan set the energy rate.
// Reset: a sweep over all 262144 lattice addresses empties the lattice and zeroes
// the bond counts; no input is taken until it ends.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module bfm_lattice_move_engine (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [2:0]  i_operation,
    input  wire logic [5:0]  i_pos_x,
    input  wire logic [5:0]  i_pos_y,
    input  wire logic [5:0]  i_pos_z,
    input  wire logic [11:0] i_segment_id,
    input  wire logic [3:0]  i_kind,
    input  wire logic [1:0]  i_bond_slot,
    input  wire logic [11:0] i_partner_id,
    input  wire logic [2:0]  i_bond_total,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic             o_occupied,
    output logic signed [6:0] o_energy,
    output logic             o_bond_ok
);
    localparam logic [3:0] S_CLR   = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_CUBE  = 4'd2;
    localparam logic [3:0] S_EKIND = 4'd3;
    localparam logic [3:0] S_NBR   = 4'd4;
    localparam logic [3:0] S_BCNT  = 4'd5;
    localparam logic [3:0] S_BN    = 4'd6;
    localparam logic [3:0] S_BPART = 4'd7;
    localparam logic [3:0] S_BPOS  = 4'd8;
    localparam logic [3:0] S_BDIST = 4'd9;
    localparam logic [3:0] S_BEVAL = 4'd10;
    localparam logic [3:0] S_SETB  = 4'd11;
    localparam logic [3:0] S_DONE  = 4'd12;

    logic [3:0]  r_state;
    logic [17:0] r_clr;
    logic [5:0]  r_step;
    logic [2:0]  r_op;
    logic [5:0]  r_x, r_y, r_z;
    logic [11:0] r_seg, r_partner;
    logic [3:0]  r_kind, r_kind_self, r_kind_p;
    logic [1:0]  r_slot;
    logic [2:0]  r_total, r_nb, r_bi;
    logic        r_hit, r_occ, r_ok;
    logic signed [6:0] r_energy;
    logic        r_o_valid, r_o_occ, r_o_ok;
    logic signed [6:0] r_o_energy;

    logic        lat_we;
    logic [17:0] lat_addr;
    logic [13:0] lat_wdata, lat_q;
    logic        kind_we;
    logic [11:0] kind_raddr;
    logic [3:0]  kind_q;
    logic        pos_we;
    logic [11:0] pos_raddr;
    logic [17:0] pos_q;
    logic        part_we;
    logic [13:0] part_raddr;
    logic [11:0] part_q;
    logic        cnt_we;
    logic [11:0] cnt_waddr;
    logic [2:0]  cnt_wdata, cnt_q;
    logic [11:0] sq;
    logic [8:0]  off;
    logic [13:0] other;
    logic        out_free;

    assign out_free = !r_o_valid || i_ready;
    assign o_ready  = (r_state == S_IDLE);
    assign o_valid    = r_o_valid;
    assign o_occupied = r_o_occ;
    assign o_energy   = r_o_energy;
    assign o_bond_ok  = r_o_ok;
    assign other      = lat_q - blme_pkg::CELL_ORIGIN;

    always_comb begin
        off        = '0;
        lat_we     = 1'b0;
        lat_addr   = {r_x, r_y, r_z};
        lat_wdata  = blme_pkg::CELL_EMPTY;
        kind_we    = 1'b0;
        kind_raddr = r_seg;
        pos_we     = 1'b0;
        pos_raddr  = part_q;
        part_we    = 1'b0;
        part_raddr = {r_seg, r_bi[1:0]};
        cnt_we     = 1'b0;
        cnt_waddr  = r_seg;
        cnt_wdata  = (r_total > 3'(blme_pkg::MaxBonds)) ? 3'(blme_pkg::MaxBonds) : r_total;
        unique case (r_state) inside
            S_CLR: begin
                lat_we    = 1'b1;
                lat_addr  = r_clr;
                cnt_we    = 1'b1;
                cnt_waddr = r_clr[11:0];
                cnt_wdata = '0;
            end
            S_CUBE: begin
                lat_addr = {r_x + 6'(r_step[2]), r_y + 6'(r_step[1]), r_z + 6'(r_step[0])};
                if (r_op == blme_pkg::OP_PLACE) begin
                    lat_we    = (r_step < 6'd8);
                    lat_wdata = (r_step == 6'd0) ? blme_pkg::CELL_ORIGIN + 14'(r_seg)
                                                 : blme_pkg::CELL_CORNER;
                    kind_we   = (r_step == 6'd0);
                    pos_we    = (r_step == 6'd0);
                end else if (r_op == blme_pkg::OP_CLEAR) begin
                    lat_we    = (r_step < 6'd8);
                end
            end
            S_NBR: begin
                if (r_step < 6'(blme_pkg::NbrCount)) begin
                    off = blme_pkg::NBR_TAB[r_step];
                end
                lat_addr = {r_x + {{3{off[8]}}, off[8:6]},
                            r_y + {{3{off[5]}}, off[5:3]},
                            r_z + {{3{off[2]}}, off[2:0]}};
                kind_raddr = other[11:0];
            end
            S_BPOS: begin
                kind_raddr = part_q;
            end
            S_SETB: begin
                part_we = ({1'b0, r_slot} < 3'(blme_pkg::MaxBonds));
                cnt_we  = 1'b1;
            end
            S_IDLE, S_EKIND, S_BCNT, S_BN, S_BPART, S_BDIST, S_BEVAL, S_DONE: begin
            end
            default: begin
            end
        endcase
    end

    blme_ram #(.AW(blme_pkg::LatBits), .DW(blme_pkg::CellBits)) u_lattice (
        .i_clk(i_clk), .i_we(lat_we), .i_waddr(lat_addr), .i_wdata(lat_wdata),
        .i_raddr(lat_addr), .o_rdata(lat_q)
    );
    blme_ram #(.AW(blme_pkg::SegBits), .DW(blme_pkg::KindBits)) u_kind (
        .i_clk(i_clk), .i_we(kind_we), .i_waddr(r_seg), .i_wdata(r_kind),
        .i_raddr(kind_raddr), .o_rdata(kind_q)
    );
    blme_ram #(.AW(blme_pkg::SegBits), .DW(blme_pkg::PosBits)) u_pos (
        .i_clk(i_clk), .i_we(pos_we), .i_waddr(r_seg), .i_wdata({r_x, r_y, r_z}),
        .i_raddr(pos_raddr), .o_rdata(pos_q)
    );
    blme_ram #(.AW(blme_pkg::PartBits), .DW(blme_pkg::SegBits)) u_partner (
        .i_clk(i_clk), .i_we(part_we), .i_waddr({r_seg, r_slot}), .i_wdata(r_partner),
        .i_raddr(part_raddr), .o_rdata(part_q)
    );
    blme_ram #(.AW(blme_pkg::SegBits), .DW(blme_pkg::CountBits)) u_count (
        .i_clk(i_clk), .i_we(cnt_we), .i_waddr(cnt_waddr), .i_wdata(cnt_wdata),
        .i_raddr(r_seg), .o_rdata(cnt_q)
    );
    blme_dist u_dist (
        .i_clk(i_clk), .i_x(r_x), .i_y(r_y), .i_z(r_z), .i_pos(pos_q), .o_sq(sq)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
            r_step    <= '0;
            r_hit     <= 1'b0;
            r_bi      <= '0;
            r_nb      <= '0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_o_valid <= 1'b1;
            end else if (r_o_valid && i_ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr <= r_clr + 18'd1;
                    if (r_clr == '1) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_op      <= i_operation;
                        r_x       <= i_pos_x;
                        r_y       <= i_pos_y;
                        r_z       <= i_pos_z;
                        r_seg     <= i_segment_id;
                        r_kind    <= i_kind;
                        r_slot    <= i_bond_slot;
                        r_partner <= i_partner_id;
                        r_total   <= i_bond_total;
                        r_occ     <= 1'b0;
                        r_ok      <= (i_operation == blme_pkg::OP_BCHECK);
                        r_energy  <= '0;
                        r_step    <= '0;
                        r_hit     <= 1'b0;
                        unique case (i_operation) inside
                            blme_pkg::OP_PLACE, blme_pkg::OP_CLEAR,
                            blme_pkg::OP_CHECK:   r_state <= S_CUBE;
                            blme_pkg::OP_ENERGY:  r_state <= S_EKIND;
                            blme_pkg::OP_BCHECK:  r_state <= S_BCNT;
                            blme_pkg::OP_SETBOND: r_state <= S_SETB;
                            default:              r_state <= S_DONE;
                        endcase
                    end
                end
                S_CUBE: begin
                    r_step <= r_step + 6'd1;
                    // Read data is registered, so it lags the address.
                    if (r_step != 6'd0 && lat_q != blme_pkg::CELL_EMPTY) begin
                        r_occ <= (r_op == blme_pkg::OP_CHECK);
                    end
                    if (r_step == 6'd8 || (r_step == 6'd7 && r_op != blme_pkg::OP_CHECK)) begin
                        r_state <= S_DONE;
                    end
                end
                S_EKIND: begin
                    r_state <= S_NBR;
                end
                S_NBR: begin
                    r_step <= r_step + 6'd1;
                    if (r_step == 6'd0) begin
                        r_kind_self <= kind_q;
                    end
                    r_hit <= (r_step != 6'd0) && (r_step <= 6'(blme_pkg::NbrCount))
                             && (lat_q >= blme_pkg::CELL_ORIGIN);
                    if (r_hit && kind_q != r_kind_self) begin
                        r_energy <= r_energy + 7'sd1;
                    end
                    if (r_step == 6'(blme_pkg::NbrCount + 1)) begin
                        r_state <= S_BCNT;
                    end
                end
                S_BCNT: begin
                    r_state <= S_BN;
                end
                S_BN: begin
                    r_nb    <= cnt_q;
                    r_bi    <= '0;
                    r_state <= S_BPART;
                end
                S_BPART: begin
                    r_state <= (r_bi == r_nb) ? S_DONE : S_BPOS;
                end
                S_BPOS: begin
                    r_state <= S_BDIST;
                end
                S_BDIST: begin
                    r_kind_p <= kind_q;
                    r_state  <= S_BEVAL;
                end
                S_BEVAL: begin
                    if (r_op == blme_pkg::OP_ENERGY) begin
                        if (sq <= 12'd6 && r_kind_p != r_kind_self) begin
                            r_energy <= r_energy - 7'sd1;
                        end
                    end else if (sq > 12'd10 || sq == 12'd8) begin
                        r_ok <= 1'b0;
                    end
                    r_bi    <= r_bi + 3'd1;
                    r_state <= S_BPART;
                end
                S_SETB: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_o_occ    <= r_occ;
                        r_o_energy <= r_energy;
                        r_o_ok     <= r_ok;
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `BLME_ASSERT(a_done_fills, i_clk, i_rst_n, (r_state == S_DONE && !r_o_valid) |=> r_o_valid, "done state did not deliver a result")
    `BLME_ASSERT(a_energy_range, i_clk, i_rst_n, r_o_valid |-> (r_o_energy >= -7'sd4 && r_o_energy <= 7'sd54), "energy result out of range")
    `BLME_ASSERT(a_bond_index, i_clk, i_rst_n, (r_state == S_BPART) |-> (r_bi <= r_nb && r_nb <= 3'(blme_pkg::MaxBonds)), "bond index ran past the bond count")
endmodule
`default_nettype wire

>>> rtl/core/blme_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module blme_ram #(
    parameter int AW = 8,
    parameter int DW = 8
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);
    logic [DW-1:0] mem [0:(1<<AW)-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule
`default_nettype wire

>>> rtl/core/blme_dist.sv
`timescale 1ns / 1ps
`default_nettype none
module blme_dist (
    input  wire logic                           i_clk,
    input  wire logic [blme_pkg::CoordBits-1:0] i_x,
    input  wire logic [blme_pkg::CoordBits-1:0] i_y,
    input  wire logic [blme_pkg::CoordBits-1:0] i_z,
    input  wire logic [blme_pkg::PosBits-1:0]   i_pos,
    output logic      [blme_pkg::SqBits-1:0]    o_sq
);
    // A difference taken modulo the period and read as signed is the minimum
    // image; the half-period tie has the same square either way.
    logic signed [blme_pkg::CoordBits-1:0] dx, dy, dz;
    logic [10:0] sx, sy, sz;

    always_comb begin
        dx = i_x - i_pos[17:12];
        dy = i_y - i_pos[11:6];
        dz = i_z - i_pos[5:0];
        sx = 11'(dx * dx);
        sy = 11'(dy * dy);
        sz = 11'(dz * dz);
    end

    always_ff @(posedge i_clk) begin
        o_sq <= {1'b0, sx} + {1'b0, sy} + {1'b0, sz};
    end
endmodule
`default_nettype wire

>>> sim/bfm_lattice_move_engine_tb.sv
`timescale 1ns / 1ps
module bfm_lattice_move_engine_tb;

    localparam int CycleLimit = 3000000;
    localparam int RandItems  = 2000;

    typedef struct packed {
        logic [2:0]  op;
        logic [5:0]  x;
        logic [5:0]  y;
        logic [5:0]  z;
        logic [11:0] seg;
        logic [3:0]  kind;
        logic [1:0]  slot;
        logic [11:0] partner;
        logic [2:0]  total;
    } move_req_t;

    typedef struct packed {
        logic              occupied;
        logic signed [6:0] energy;
        logic              bond_ok;
    } move_res_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    move_req_t cur = '0;
    logic o_ready, o_valid, o_occupied, o_bond_ok;
    logic signed [6:0] o_energy;

    bfm_lattice_move_engine u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (in_valid),
        .o_ready      (o_ready),
        .i_operation  (cur.op),
        .i_pos_x      (cur.x),
        .i_pos_y      (cur.y),
        .i_pos_z      (cur.z),
        .i_segment_id (cur.seg),
        .i_kind       (cur.kind),
        .i_bond_slot  (cur.slot),
        .i_partner_id (cur.partner),
        .i_bond_total (cur.total),
        .o_valid      (o_valid),
        .i_ready      (out_ready),
        .o_occupied   (o_occupied),
        .o_energy     (o_energy),
        .o_bond_ok    (o_bond_ok)
    );

    // Shadow copy of the lattice and the segment tables.
    logic [blme_pkg::CellBits-1:0] lat_cells [0:262143];
    logic [3:0]          seg_kind [0:4095];
    logic [5:0]          seg_x [0:4095];
    logic [5:0]          seg_y [0:4095];
    logic [5:0]          seg_z [0:4095];
    logic [11:0]         bond_partner [0:4095][0:blme_pkg::MaxBonds-1];
    logic [2:0]          bond_count [0:4095];
    int                  nbr_off [0:blme_pkg::NbrCount-1][0:2];

    // Generator-side bookkeeping so that no unwritten table entry is ever read.
    bit                  gen_placed [0:4095];
    logic [3:0]          gen_slots [0:4095];
    int                  placed_list [$];

    move_req_t pending_q [$];
    move_res_t result_q [$];
    bit        taken = 0;
    int        acc_n = 0;
    int        n_err = 0;
    int        cycles = 0;
    int        hold_left = 0;
    bit        hold_done = 0;

    function automatic logic [17:0] cell_at(logic [5:0] x, logic [5:0] y, logic [5:0] z);
        return {x, y, z};
    endfunction

    function automatic int wrap_diff(int d);
        if (d > 32) return d - 64;
        if (d < -32) return d + 64;
        return d;
    endfunction

    function automatic int bond_len_sq(logic [5:0] x, logic [5:0] y, logic [5:0] z,
                                       logic [11:0] p);
        int dx, dy, dz;
        dx = wrap_diff(int'(x) - int'(seg_x[p]));
        dy = wrap_diff(int'(y) - int'(seg_y[p]));
        dz = wrap_diff(int'(z) - int'(seg_z[p]));
        return dx * dx + dy * dy + dz * dz;
    endfunction

    task automatic apply_move_op(input move_req_t r, output move_res_t res);
        logic [17:0] cube [0:7];
        logic [5:0] x1, y1, z1;
        logic [blme_pkg::CellBits-1:0] c;
        logic [11:0] p;
        int e;
        int len;
        res = '0;
        x1 = r.x + 6'd1;
        y1 = r.y + 6'd1;
        z1 = r.z + 6'd1;
        cube[0] = cell_at(r.x, r.y, r.z);
        cube[1] = cell_at(r.x, r.y, z1);
        cube[2] = cell_at(r.x, y1, r.z);
        cube[3] = cell_at(r.x, y1, z1);
        cube[4] = cell_at(x1, r.y, r.z);
        cube[5] = cell_at(x1, r.y, z1);
        cube[6] = cell_at(x1, y1, r.z);
        cube[7] = cell_at(x1, y1, z1);
        case (r.op)
            blme_pkg::OP_PLACE: begin
                lat_cells[cube[0]] = blme_pkg::CELL_ORIGIN + blme_pkg::CellBits'(r.seg);
                for (int i = 1; i < 8; i++) lat_cells[cube[i]] = blme_pkg::CELL_CORNER;
                seg_kind[r.seg] = r.kind;
                seg_x[r.seg] = r.x;
                seg_y[r.seg] = r.y;
                seg_z[r.seg] = r.z;
            end
            blme_pkg::OP_CLEAR: begin
                for (int i = 0; i < 8; i++) lat_cells[cube[i]] = blme_pkg::CELL_EMPTY;
            end
            blme_pkg::OP_CHECK: begin
                for (int i = 0; i < 8; i++)
                    if (lat_cells[cube[i]] != blme_pkg::CELL_EMPTY) res.occupied = 1'b1;
            end
            blme_pkg::OP_ENERGY: begin
                e = 0;
                for (int i = 0; i < blme_pkg::NbrCount; i++) begin
                    c = lat_cells[cell_at(6'(int'(r.x) + nbr_off[i][0]),
                                          6'(int'(r.y) + nbr_off[i][1]),
                                          6'(int'(r.z) + nbr_off[i][2]))];
                    if (c >= blme_pkg::CELL_ORIGIN &&
                        seg_kind[12'(c - blme_pkg::CELL_ORIGIN)] != seg_kind[r.seg])
                        e++;
                end
                for (int i = 0; i < bond_count[r.seg]; i++) begin
                    p = bond_partner[r.seg][i];
                    if (bond_len_sq(r.x, r.y, r.z, p) <= 6 && seg_kind[p] != seg_kind[r.seg])
                        e--;
                end
                res.energy = 7'(e);
            end
            blme_pkg::OP_BCHECK: begin
                res.bond_ok = 1'b1;
                for (int i = 0; i < bond_count[r.seg]; i++) begin
                    len = bond_len_sq(r.x, r.y, r.z, bond_partner[r.seg][i]);
                    if (len > 10 || len == 8) res.bond_ok = 1'b0;
                end
            end
            blme_pkg::OP_SETBOND: begin
                bond_partner[r.seg][r.slot] = r.partner;
                bond_count[r.seg] = (r.total > blme_pkg::MaxBonds) ?
                                    3'(blme_pkg::MaxBonds) : r.total;
            end
            default: ;
        endcase
    endtask

    // Number of bond slots written without a gap, counting up from slot 0.
    function automatic int filled_slots(logic [3:0] w);
        int k;
        k = 0;
        while (k < blme_pkg::MaxBonds && w[k]) k++;
        return k;
    endfunction

    task automatic push_item(input logic [2:0] op, input int x, input int y, input int z,
                             input int seg, input int kind = 0, input int slot = 0,
                             input int partner = 0, input int total = 0);
        move_req_t r;
        r.op = op;
        r.x = 6'(x);
        r.y = 6'(y);
        r.z = 6'(z);
        r.seg = 12'(seg);
        r.kind = 4'(kind);
        r.slot = 2'(slot);
        r.partner = 12'(partner);
        r.total = 3'(total);
        if (op == blme_pkg::OP_PLACE && !gen_placed[r.seg]) begin
            gen_placed[r.seg] = 1;
            placed_list.push_back(r.seg);
        end
        if (op == blme_pkg::OP_SETBOND) gen_slots[r.seg][r.slot] = 1'b1;
        pending_q.push_back(r);
    endtask

    function automatic int rand_coord(int base);
        if ($urandom_range(3) == 0) return $urandom_range(63);
        return (base + $urandom_range(5)) % 64;
    endfunction

    task automatic gen_random_item();
        int sel, base, seg, slot, k, total;
        logic [2:0] op;
        sel = $urandom_range(99);
        base = ($urandom_range(2) == 0) ? 61 : ($urandom_range(1) ? 0 : 28);
        if (sel < 25) op = blme_pkg::OP_PLACE;
        else if (sel < 33) op = blme_pkg::OP_CLEAR;
        else if (sel < 47) op = blme_pkg::OP_CHECK;
        else if (sel < 67) op = blme_pkg::OP_ENERGY;
        else if (sel < 79) op = blme_pkg::OP_BCHECK;
        else if (sel < 95) op = blme_pkg::OP_SETBOND;
        else op = 3'($urandom_range(7, 6));
        seg = ($urandom_range(4) == 0) ? $urandom_range(4095) : $urandom_range(31);
        if (op == blme_pkg::OP_ENERGY || op == blme_pkg::OP_BCHECK ||
            op == blme_pkg::OP_SETBOND)
            seg = placed_list[$urandom_range(placed_list.size() - 1)];
        if (op == blme_pkg::OP_SETBOND) begin
            slot = $urandom_range(3);
            k = filled_slots(gen_slots[seg] | (4'b1 << slot));
            total = (k == blme_pkg::MaxBonds) ? $urandom_range(7) : $urandom_range(k);
            push_item(op, rand_coord(base), rand_coord(base), rand_coord(base), seg,
                      $urandom_range(15), slot,
                      placed_list[$urandom_range(placed_list.size() - 1)], total);
        end else begin
            push_item(op, rand_coord(base), rand_coord(base), rand_coord(base), seg,
                      $urandom_range(15), $urandom_range(3), $urandom_range(4095),
                      $urandom_range(7));
        end
    endtask

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Driver: a new item goes out only once the previous one made its transfer.
    always @(negedge i_clk) begin
        int idle_pct;
        idle_pct = (acc_n < 700) ? 18 : (acc_n < 1400) ? 66 : 0;
        if (i_rst_n && (!in_valid || taken)) begin
            taken = 0;
            if (pending_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
                cur <= pending_q.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver, including one long hold-off while the sender keeps offering items.
    always @(negedge i_clk) begin
        int idle_pct;
        idle_pct = (acc_n < 700) ? 66 : (acc_n < 1400) ? 18 : 0;
        if (!hold_done && acc_n >= 1500) begin
            hold_done = 1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // Monitor: predicts on each input transfer and checks each output transfer.
    always @(posedge i_clk) begin
        move_res_t want;
        move_res_t got;
        cycles++;
        if (cycles > CycleLimit) begin
            $display("status: fail");
            $finish;
        end else begin
            if (i_rst_n && in_valid && o_ready) begin
                apply_move_op(cur, want);
                result_q.push_back(want);
                taken = 1;
                acc_n++;
            end
            if (i_rst_n && o_valid && out_ready) begin
                got = '{o_occupied, o_energy, o_bond_ok};
                if (result_q.size() == 0) begin
                    n_err++;
                    if (n_err <= 10) $display("unexpected result %p", got);
                end else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        n_err++;
                        if (n_err <= 10)
                            $display("mismatch: expected %p, got %p", want, got);
                    end
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < 262144; i++) lat_cells[i] = blme_pkg::CELL_EMPTY;
        for (int i = 0; i < 4096; i++) begin
            bond_count[i] = '0;
            gen_placed[i] = 0;
            gen_slots[i] = '0;
        end
        begin
            int n;
            n = 0;
            for (int dx = -2; dx <= 2; dx++)
                for (int dy = -2; dy <= 2; dy++)
                    for (int dz = -2; dz <= 2; dz++)
                        if (dx * dx + dy * dy + dz * dz inside {[4:6]}) begin
                            nbr_off[n][0] = dx;
                            nbr_off[n][1] = dy;
                            nbr_off[n][2] = dz;
                            n++;
                        end
        end

        // Directed part: corners of the grid, wrapped cubes, every code, saturation.
        push_item(blme_pkg::OP_PLACE, 0, 0, 0, 0, 0);
        push_item(blme_pkg::OP_PLACE, 63, 63, 63, 4095, 15);
        push_item(blme_pkg::OP_CHECK, 0, 0, 0, 0);
        push_item(blme_pkg::OP_CHECK, 63, 63, 63, 0);
        push_item(blme_pkg::OP_CHECK, 30, 30, 30, 0);
        push_item(blme_pkg::OP_PLACE, 2, 0, 0, 1, 5);
        push_item(blme_pkg::OP_PLACE, 0, 2, 1, 2, 5);
        push_item(blme_pkg::OP_ENERGY, 0, 0, 0, 0);
        push_item(blme_pkg::OP_SETBOND, 0, 0, 0, 0, 0, 0, 1, 1);
        push_item(blme_pkg::OP_ENERGY, 0, 0, 0, 0);
        push_item(blme_pkg::OP_BCHECK, 0, 0, 0, 0);
        push_item(blme_pkg::OP_SETBOND, 0, 0, 0, 0, 0, 1, 2, 2);
        push_item(blme_pkg::OP_SETBOND, 0, 0, 0, 0, 0, 2, 4095, 3);
        // A bond total above the slot count saturates at four.
        push_item(blme_pkg::OP_SETBOND, 0, 0, 0, 0, 0, 3, 1, 7);
        push_item(blme_pkg::OP_ENERGY, 0, 0, 0, 0);
        push_item(blme_pkg::OP_BCHECK, 0, 0, 0, 0);
        push_item(blme_pkg::OP_BCHECK, 10, 10, 10, 0);
        push_item(3'd6, 63, 63, 63, 4095, 15, 3, 4095, 7);
        push_item(3'd7, 0, 0, 0, 0);
        push_item(blme_pkg::OP_CLEAR, 63, 63, 63, 0);
        push_item(blme_pkg::OP_CHECK, 63, 63, 63, 0);
        push_item(blme_pkg::OP_PLACE, 1, 1, 1, 3, 9);
        push_item(blme_pkg::OP_ENERGY, 2, 0, 0, 1);
        push_item(blme_pkg::OP_ENERGY, 63, 63, 63, 4095);
        for (int i = 0; i < RandItems; i++) gen_random_item();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_q.size() == 0 && !in_valid);
        wait (result_q.size() == 0);
        repeat (200) @(posedge i_clk);
        if (n_err == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
